// ----- hdl/assert_macros.svh -----
// Assertion helpers for the report filter block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- hdl/arf_pkg.sv -----
package arf_pkg;
  localparam int TableDepth = 16;
  localparam int ReportBytes = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int PosW = $clog2(ReportBytes + 1);
  localparam int BufW = $clog2(ReportBytes);
  localparam int UsedW = $clog2(TableDepth + 1);
  // walk positions may run past the buffer; keep room for a full 255-byte field jump
  localparam int WalkW = PosW + 3;

  localparam logic [7:0] TypeCompleteName = 8'h09;
  localparam logic [7:0] TypeShortName = 8'h08;
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam int FirstWordByte = 13;

  localparam logic [31:0] PrefixReset = 32'd1195520048;
  localparam logic [1:0] RegNamePrefix = 2'd0;

  localparam logic [1:0] StatReject = 2'd0;
  localparam logic [1:0] StatUpdate = 2'd1;
  localparam logic [1:0] StatInsert = 2'd2;
  localparam logic [1:0] StatFull = 2'd3;

  // result of the name check handed from the scanner to the table
  typedef struct packed {
    logic matched;
    logic [15:0] id;
    logic [63:0] words;
  } scan_res_t;
endpackage

// ----- hdl/adv_report_filter_device_table.sv -----
// Report filter with device table.
// A final byte of a report starts a field walk (length, then type, of each field),
// a name check and a word fetch on the shared byte port, then a table search and
// update to the result.
// Result beats sit in an output register; a new report starts once it is taken.
// rst is synchronous: counters, table fill and name_prefix go to reset values.
`include "assert_macros.svh"
module adv_report_filter_device_table import arf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] data_byte,
  input  logic [47:0] adv_addr,
  input  logic last_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [3:0] entry_index,
  output logic [31:0] seen_count,
  output logic [15:0] device_id,
  output logic [15:0] value_zero,
  output logic [15:0] value_one,
  output logic [15:0] value_two,
  output logic [15:0] value_three,
  output logic [31:0] accepted_count
);
  logic [31:0] name_prefix;
  logic busy, sdone, tfin, tbusy, accept;
  scan_res_t res;
  logic [47:0] addr_q;
  logic [1:0] t_stat;
  logic [IdxW-1:0] t_slot;
  logic [31:0] t_cnt;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == RegNamePrefix) ? name_prefix : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) name_prefix <= PrefixReset;
    else if (psel && penable && pwrite && paddr == RegNamePrefix) name_prefix <= pwdata;
  end

  assign in_ready = !busy && !tbusy && !sdone && !out_valid;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) if (accept && last_byte) addr_q <= adv_addr;

  arf_scan u_scan (.clk, .rst, .name_prefix, .byte_valid(accept), .data_byte,
    .last_byte, .busy, .done(sdone), .res);
  arf_table u_tab (.clk, .rst, .start(sdone), .res, .addr(addr_q), .fin(tfin),
    .status(t_stat), .slot(t_slot), .cnt(t_cnt));

  // table is busy from scan done until its result lands
  always_ff @(posedge clk) begin
    if (rst) tbusy <= 1'b0;
    else if (sdone) tbusy <= 1'b1;
    else if (tfin) tbusy <= 1'b0;
  end

  // hold result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; accepted_count <= '0;
    end else begin
      if (tfin) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (tfin) begin
        status <= t_stat;
        if (t_stat != StatReject) accepted_count <= accepted_count + 1'b1;
        if (t_stat == StatUpdate || t_stat == StatInsert) begin
          entry_index <= 4'(t_slot); seen_count <= t_cnt;
          device_id <= res.id; value_zero <= res.words[63:48];
          value_one <= res.words[47:32]; value_two <= res.words[31:16];
          value_three <= res.words[15:0];
        end else begin
          entry_index <= '0; seen_count <= '0; device_id <= '0; value_zero <= '0;
          value_one <= '0; value_two <= '0; value_three <= '0;
        end
      end
    end
  end

  `ASSERT_NEVER(a_no_overrun, clk, rst, tfin && out_valid, "result overrun")
  `ASSERT_IMPL(a_block, clk, rst, out_valid |-> !in_ready, "input while result held")
  `ASSERT_NEVER(a_both, clk, rst, busy && tbusy && sdone, "scan done while table busy")
endmodule

// ----- hdl/arf_scan.sv -----
`include "assert_macros.svh"
module arf_scan import arf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic [31:0] name_prefix,
  input  logic byte_valid,
  input  logic [7:0] data_byte,
  input  logic last_byte,
  output logic busy,
  output logic done,
  output scan_res_t res
);
  typedef enum logic [2:0] {S_IDLE, S_WALK, S_NAME, S_WORDS, S_DONE} state_t;
  state_t state;
  logic [7:0] buf_mem [ReportBytes];
  logic [PosW-1:0] len;
  logic [WalkW-1:0] field, cstart, sstart, rptr;
  logic cfound, sfound;
  logic [3:0] k;
  logic ok;
  logic [7:0] rbyte;
  logic [7:0] want;

  // single shared byte read port; out of range reads zero
  always_comb begin
    rbyte = 8'd0;
    if (rptr < WalkW'(len)) rbyte = buf_mem[rptr[BufW-1:0]];
  end

  always_comb begin
    case (k[1:0])
      2'd0: want = name_prefix[31:24];
      2'd1: want = name_prefix[23:16];
      2'd2: want = name_prefix[15:8];
      default: want = name_prefix[7:0];
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (byte_valid && state == S_IDLE && len < PosW'(ReportBytes))
      buf_mem[len[BufW-1:0]] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; len <= '0; done <= 1'b0;
      field <= '0; cfound <= 1'b0; sfound <= 1'b0; k <= '0; rptr <= '0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: if (byte_valid) begin
          if (len < PosW'(ReportBytes)) len <= len + 1'b1;
          if (last_byte) begin
            state <= S_WALK; field <= '0; cfound <= 1'b0; sfound <= 1'b0;
            rptr <= '0; k <= '0;
          end
        end
        // step 0 reads length, step 1 reads type
        S_WALK: begin
          if (k == 4'd0) begin
            if (field >= WalkW'(len) || rbyte == 8'd0) begin
              state <= S_NAME; k <= '0; ok <= 1'b1;
              rptr <= cfound ? cstart : sstart;
            end else begin
              field <= field + WalkW'(rbyte) + 1'b1;
              rptr <= field + 1'b1; k <= 4'd1;
            end
          end else begin
            if (rbyte == TypeCompleteName && !cfound) begin
              cfound <= 1'b1; cstart <= rptr + 1'b1;
            end
            if (rbyte == TypeShortName && !sfound) begin
              sfound <= 1'b1; sstart <= rptr + 1'b1;
            end
            rptr <= field; k <= 4'd0;
          end
        end
        // check six name bytes one per cycle: four against name_prefix, two as ASCII digits
        S_NAME: begin
          if (k < 4'd4) begin
            if (rbyte != want) ok <= 1'b0;
          end else if (rbyte < AsciiZero || rbyte > AsciiNine) ok <= 1'b0;
          if (k == 4'd5) begin
            state <= S_WORDS; k <= '0; rptr <= WalkW'(FirstWordByte);
          end else begin
            k <= k + 1'b1; rptr <= rptr + 1'b1;
          end
        end
        S_WORDS: begin
          if (k < 4'd2) res.id <= {res.id[7:0], rbyte};
          else res.words <= {res.words[55:0], rbyte};
          rptr <= rptr + 1'b1;
          if (k == 4'd9) begin
            state <= S_DONE;
            res.matched <= ok && (cfound || sfound);
          end else k <= k + 1'b1;
        end
        S_DONE: begin
          len <= '0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_done_one, clk, rst, done |=> !done, "done longer than a cycle")
  `ASSERT_IMPL(a_len_max, clk, rst, len <= PosW'(ReportBytes), "length overflow")
  `ASSERT_NEVER(a_byte_busy, clk, rst, byte_valid && state == S_WALK && k == 4'd15,
    "bad walk step")
endmodule

// ----- hdl/arf_table.sv -----
`include "assert_macros.svh"
module arf_table import arf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  scan_res_t res,
  input  logic [47:0] addr,
  output logic fin,
  output logic [1:0] status,
  output logic [IdxW-1:0] slot,
  output logic [31:0] cnt
);
  typedef enum logic [1:0] {T_IDLE, T_SRCH, T_RD, T_WR} state_t;
  state_t state;
  logic [47:0] addr_mem [TableDepth];
  logic [31:0] cnt_mem [TableDepth];
  logic [UsedW-1:0] used, k;
  logic [47:0] rd_addr;
  logic [31:0] rd_cnt;
  logic hit, at_end;
  logic [31:0] cnt_upd;

  // the read is registered, so entry k-1 is compared, the last one too
  assign hit = (k != '0) && (rd_addr == addr);
  assign at_end = (k >= used);
  assign cnt_upd = (status == StatInsert) ? 32'd1 : rd_cnt + 32'd1;

  always_ff @(posedge clk) begin
    rd_addr <= addr_mem[k[IdxW-1:0]];
    rd_cnt <= cnt_mem[slot];
    if (state == T_WR) cnt_mem[slot] <= cnt_upd;
    if (state == T_RD && status == StatInsert) addr_mem[slot] <= addr;
  end

  // one compare a cycle through the used entries, then update the hit, insert, or flag full
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE; used <= '0; fin <= 1'b0; k <= '0;
    end else begin
      fin <= (state == T_IDLE && start && !res.matched) ||
             (state == T_SRCH && !hit && at_end && used >= UsedW'(TableDepth)) ||
             (state == T_WR);
      case (state)
        T_IDLE: if (start) begin
          k <= '0; slot <= '0; cnt <= '0;
          if (!res.matched) status <= StatReject;
          else state <= T_SRCH;
        end
        T_SRCH: begin
          if (hit) begin
            status <= StatUpdate; slot <= IdxW'(k - 1'b1); state <= T_RD;
          end else if (at_end) begin
            if (used < UsedW'(TableDepth)) begin
              status <= StatInsert; slot <= used[IdxW-1:0];
              used <= used + 1'b1; state <= T_RD;
            end else begin
              status <= StatFull; state <= T_IDLE;
            end
          end else k <= k + 1'b1;
        end
        T_RD: state <= T_WR;
        T_WR: begin
          cnt <= cnt_upd; state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_used, clk, rst, used <= UsedW'(TableDepth), "table overfull")
  `ASSERT_IMPL(a_fin, clk, rst, fin |=> !fin, "fin held")
  `ASSERT_NEVER(a_start_idle, clk, rst, start && state != T_IDLE, "start while searching")
endmodule
